/* hdl/bmhpq_pkg.sv */
package bmhpq_pkg;

  // Field widths fixed by the interface
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned PAY_W    = 16;
  localparam int unsigned ENTRY_W  = PRIO_W + PAY_W;
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOP_W    = PRIO_W + 1;

  // Default queue depth and reset value of the capacity register
  localparam int unsigned       DEPTH_DEFAULT = 64;
  localparam logic [CAP_W-1:0]  CAP_RESET     = 7'd64;

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // One heap entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]  pay;
  } entry_t;

endpackage

/* hdl/bmhpq_ram.sv */
module bmhpq_ram
  import bmhpq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [ENTRY_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_a_i,
  input  logic [AW-1:0]      rd_addr_b_i,
  output logic [ENTRY_W-1:0] rd_data_a_o,
  output logic [ENTRY_W-1:0] rd_data_b_o
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem[rd_addr_a_i];
      rd_data_b_o <= mem[rd_addr_b_i];
    end
  end

endmodule

/* hdl/binary_min_heap_priority_queue_unit.sv */
// Binary min-heap priority queue. A lower priority number is served first.
// Input channel (in_valid_i / in_stall_o): func_i selects insert or remove;
// priority_req_i and payload_i give the entry to insert. One result word per
// input word leaves on the output channel (out_valid_o / out_stall_i) with a
// status, the removed entry (zero when nothing was removed), the root
// priority after the operation (-1 when empty) and the entry count.
// capacity_limit is written through cfg_valid_i / cfg_ready_o / cfg_data_i
// only while the queue is idle, a rule the user must keep: the block itself
// does not enforce it. Values above DEPTH behave as DEPTH.
// Timing: one word is worked on at a time. A rejected insert, an empty remove
// or the removal of the last entry goes from S_IDLE straight to S_FINISH.
// An insert moves its entry up, each level costing a read of the single heap
// memory in S_UP_RD and a compare-and-write in S_UP_CMP; it ends with a write
// in S_UP_RD when the entry reaches the root. A remove loads the last entry in
// S_DN_LOAD and moves it down the same way through S_DN_RD and S_DN_CMP,
// ending with a write in S_DN_RD when it reaches a leaf. A finished result
// waits in the output register while the receiver stalls; the next word is
// accepted meanwhile, and its result waits in the FSM until the register
// frees. Reset empties the queue and sets capacity_limit to 64; heap memory
// contents are not cleared, as only entries below the count are ever used.
module binary_min_heap_priority_queue_unit
  import bmhpq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CAP_W-1:0]           cfg_data_i,
  // Request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic [PRIO_W-1:0]          priority_req_i,
  input  logic [PAY_W-1:0]           payload_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic [PAY_W-1:0]           removed_payload_o,
  output logic [PRIO_W-1:0]          removed_priority_o,
  output logic signed [TOP_W-1:0]    top_priority_o,
  output logic [CNT_W-1:0]           entry_count_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = AW + 1;
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CAP_W-1:0]    cap_q, cap_d;
  logic [AW-1:0]       hole_q, hole_d;
  entry_t              item_q, item_d;
  entry_t              root_q, root_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  entry_t              res_entry_q, res_entry_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  entry_t              out_entry_q, out_entry_d;
  logic [TOP_W-1:0]    out_top_q, out_top_d;
  logic [CNT_W-1:0]    out_cnt_q, out_cnt_d;

  // Memory access
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr_a, rd_addr_b;
  entry_t              rd_a, rd_b;

  // Heap index arithmetic
  logic [AW-1:0]       parent;
  logic [XW-1:0]       left_w, right_w, cnt_x;
  logic                left_ok, right_ok;
  logic                ins_full;
  logic [PRIO_W-1:0]   best_prio;
  logic                sel_left, sel_right;
  logic                out_free;

  bmhpq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_en_i     (rd_en),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  // Parent and children of the hole
  assign parent   = (hole_q - AW'(1)) >> 1;
  assign left_w   = {hole_q, 1'b1};
  assign right_w  = left_w + XW'(1);
  assign cnt_x    = XW'(cnt_q);
  assign left_ok  = left_w < cnt_x;
  assign right_ok = right_w < cnt_x;

  // Full when the count reaches the limit or the depth
  assign ins_full = (CMP_W'(cnt_q) >= CMP_W'(cap_q)) || (cnt_q == CNT_W'(DEPTH));

  // Pick the smallest of item and children; a child wins ties, and the right child wins a tie with the left
  assign sel_left  = rd_a.prio <= item_q.prio;
  assign best_prio = sel_left ? rd_a.prio : item_q.prio;
  assign sel_right = right_ok && (rd_b.prio <= best_prio);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cap_d        = cap_q;
    hole_d       = hole_q;
    item_d       = item_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_top_d    = out_top_q;
    out_cnt_d    = out_cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    wr_en        = 1'b0;
    wr_addr      = hole_q;
    wr_data      = item_q;
    rd_en        = 1'b0;
    rd_addr_a    = '0;
    rd_addr_b    = '0;

    if (cfg_valid_i) begin
      cap_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_entry_d  = '0;
          if (func_i == FUNC_INSERT) begin
            if (ins_full) begin
              res_status_d = ST_FULL;
              state_d      = S_FINISH;
            end else begin
              item_d  = '{prio: priority_req_i, pay: payload_i};
              hole_d  = AW'(cnt_q);
              cnt_d   = cnt_q + CNT_W'(1);
              state_d = S_UP_RD;
            end
          end else if (cnt_q == '0) begin
            res_status_d = ST_EMPTY;
            state_d      = S_FINISH;
          end else begin
            res_entry_d = root_q;
            cnt_d       = cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_d = S_FINISH;
            end else begin
              // fetch the last entry, it moves to the root
              rd_en     = 1'b1;
              rd_addr_a = AW'(cnt_q - CNT_W'(1));
              state_d   = S_DN_LOAD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (hole_q == '0) begin
          wr_en   = 1'b1;
          state_d = S_FINISH;
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = parent;
          state_d   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_a.prio > item_q.prio) begin
          // move the parent down into the hole
          wr_data = rd_a;
          hole_d  = parent;
          state_d = S_UP_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_DN_LOAD: begin
        item_d  = rd_a;
        hole_d  = '0;
        state_d = S_DN_RD;
      end
      S_DN_RD: begin
        if (!left_ok) begin
          wr_en   = 1'b1;
          state_d = S_FINISH;
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = AW'(left_w);
          rd_addr_b = AW'(right_w);
          state_d   = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (sel_right) begin
          wr_data = rd_b;
          hole_d  = AW'(right_w);
          state_d = S_DN_RD;
        end else if (sel_left) begin
          wr_data = rd_a;
          hole_d  = AW'(left_w);
          state_d = S_DN_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_entry_d  = res_entry_q;
          out_top_d    = (cnt_q == '0) ? '1 : {1'b0, root_q.prio};
          out_cnt_d    = cnt_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Mirror the root entry
    root_d = root_q;
    if (wr_en && (wr_addr == '0)) begin
      root_d = wr_data;
    end
  end

  // Control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hole_q       <= hole_d;
    item_q       <= item_d;
    root_q       <= root_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_top_q    <= out_top_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign cfg_ready_o        = 1'b1;
  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign removed_payload_o  = out_entry_q.pay;
  assign removed_priority_o = out_entry_q.prio;
  assign top_priority_o     = out_top_q;
  assign entry_count_o      = out_cnt_q;

endmodule

/* hdl/bmhpq_checker.sv */
module bmhpq_checker
  import bmhpq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  logic [STATUS_W-1:0]     status_o,
  input  logic [PAY_W-1:0]        removed_payload_o,
  input  logic [PRIO_W-1:0]       removed_priority_o,
  input  logic signed [TOP_W-1:0] top_priority_o,
  input  logic [CNT_W-1:0]        entry_count_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(removed_payload_o) && $stable(removed_priority_o)
      && $stable(top_priority_o) && $stable(entry_count_o))
    else $error("result word changed while stalled");

  // Empty queue and -1 top priority go together
  a_top_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((entry_count_o == '0) == (top_priority_o == -1)))
    else $error("top priority disagrees with entry count");

  // A failed operation removes nothing
  a_no_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      (removed_payload_o == '0) && (removed_priority_o == '0))
    else $error("removed entry reported on failed operation");

  // An empty remove leaves an empty queue
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (entry_count_o == '0))
    else $error("empty status with entries held");

endmodule

bind binary_min_heap_priority_queue_unit bmhpq_checker #(.DEPTH(DEPTH)) u_bmhpq_checker (.*);
